FILE: hdl/kmp_stream_matcher_top_assert.svh
// Assertion macros for the streaming pattern matcher.
// Define NO_ASSERTIONS to compile them out.
`ifndef KMP_STREAM_MATCHER_TOP_ASSERT_SVH
`define KMP_STREAM_MATCHER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds in the same cycle as ante.
`define KMP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kmp_stream_matcher: assertion failed");
// Check that cons holds in the cycle after ante.
`define KMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kmp_stream_matcher: assertion failed");
`else
`define KMP_ASSERT_NOW(label, ante, cons)
`define KMP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/kmp_pkg.sv
`default_nettype none

package kmp_pkg;

  // Default pattern capacity in bytes
  localparam int unsigned MAX_PATTERN_DEF = 1024;
  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned POS_W = 32;

  // Request codes on the input channel
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_TEXT   = 2'd2
  } req_e;

  // Commands handed from the front to the back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_TEXT
  } op_e;

  // Back engine states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_FAIL
  } st_e;

  typedef struct packed {
    op_e              op;
    logic [SYM_W-1:0] sym;
    logic             eot;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/kmp_if.sv
`default_nettype none

// Input channel: one request per item
interface kmp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] symbol;
  logic       end_of_text;

  modport source (output valid, output req_type, output symbol, output end_of_text,
                  input ready);
  modport sink (input valid, input req_type, input symbol, input end_of_text,
                output ready);
endinterface

// Output channel: one match start position per item
interface kmp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_start;

  modport source (output valid, output match_start, input ready);
  modport sink (input valid, input match_start, output ready);
endinterface

`default_nettype wire

FILE: hdl/kmp_ram.sv
`default_nettype none

module kmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/kmp_front.sv
`default_nettype none

module kmp_front import kmp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kmp_in_if.sink      in_i,
  output cmd_t        cmd_o,
  output logic        cmd_vld_o,
  input  wire logic   cmd_pop_i
);

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           q_mem [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  cmd_t           cls;
  logic           keep;
  logic           push;

  // Classify the request; undefined codes are dropped
  always_comb begin
    cls.sym = in_i.symbol;
    cls.eot = in_i.end_of_text;
    cls.op  = OP_CLEAR;
    keep    = 1'b1;
    unique case (req_e'(in_i.req_type))
      REQ_CLEAR:  cls.op = OP_CLEAR;
      REQ_APPEND: cls.op = OP_APPEND;
      REQ_TEXT:   cls.op = OP_TEXT;
      default:    keep = 1'b0;
    endcase
  end

  assign in_i.ready = (cnt_q != QCW'(QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready && keep;
  assign cmd_vld_o  = (cnt_q != '0);
  assign cmd_o      = q_mem[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QAW'(1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCW'(push) - QCW'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified item
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/kmp_back.sv
`default_nettype none

module kmp_back import kmp_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cmd_t   cmd_i,
  input  wire logic   cmd_vld_i,
  output logic        cmd_pop_o,
  kmp_out_if.source   out_o
);

  localparam int unsigned IW = $clog2(MAX_PATTERN);
  localparam int unsigned LW = $clog2(MAX_PATTERN + 1);

  st_e              st_q, st_d;
  logic [LW-1:0]    j_q, j_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic             is_text_q, is_text_d;
  logic             eot_q, eot_d;
  logic [LW-1:0]    plen_q, plen_d;
  logic [IW-1:0]    pref_q, pref_d;
  logic [LW-1:0]    mp_q, mp_d;
  logic [POS_W-1:0] tp_q, tp_d;
  logic             out_vld_q, out_vld_d;
  logic [POS_W-1:0] out_q, out_d;

  logic             p_we, f_we;
  logic [IW-1:0]    p_raddr, f_raddr, f_wdata;
  logic [SYM_W-1:0] p_rdata;
  logic [IW-1:0]    f_rdata;

  logic             out_free, dispatch, plen_full, plen_zero;
  logic             hit, fin;
  logic [LW-1:0]    j_start, j_fail, j_fin, j_dec;

  // Pattern bytes and failure links
  kmp_ram #(.WIDTH(SYM_W), .DEPTH(MAX_PATTERN)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (plen_q[IW-1:0]),
    .wdata_i (cmd_i.sym),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  kmp_ram #(.WIDTH(IW), .DEPTH(MAX_PATTERN)) u_fail_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (plen_q[IW-1:0]),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  // Shared conditions
  assign out_free  = !out_vld_q || out_o.ready;
  assign dispatch  = (st_q == ST_IDLE) && cmd_vld_i && ((cmd_i.op != OP_TEXT) || out_free);
  assign plen_full = (plen_q == LW'(MAX_PATTERN));
  assign plen_zero = (plen_q == '0);
  assign j_start   = (mp_q >= plen_q) ? '0 : mp_q;
  assign j_fail    = (LW'(f_rdata) < j_q) ? LW'(f_rdata) : '0;
  assign hit       = (p_rdata == sym_q);
  assign fin       = hit || (j_q == '0);
  assign j_fin     = hit ? j_q + LW'(1) : '0;
  assign j_dec     = j_q - LW'(1);
  assign f_raddr   = j_dec[IW-1:0];
  assign cmd_pop_o = dispatch;

  assign out_o.valid       = out_vld_q;
  assign out_o.match_start = out_q;

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (dispatch && (cmd_i.op == OP_APPEND) && !plen_full && !plen_zero) begin
          st_d = ST_CMP;
        end else if (dispatch && (cmd_i.op == OP_TEXT) && !plen_zero) begin
          st_d = ST_CMP;
        end
      end
      ST_CMP:  st_d = fin ? ST_IDLE : ST_FAIL;
      ST_FAIL: st_d = ST_CMP;
      default: st_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    j_d       = j_q;
    sym_d     = sym_q;
    is_text_d = is_text_q;
    eot_d     = eot_q;
    plen_d    = plen_q;
    pref_d    = pref_q;
    mp_d      = mp_q;
    tp_d      = tp_q;
    out_vld_d = out_vld_q && !out_o.ready;
    out_d     = out_q;
    p_we      = 1'b0;
    f_we      = 1'b0;
    f_wdata   = '0;
    p_raddr   = j_q[IW-1:0];
    unique case (st_q)
      ST_IDLE: begin
        if (dispatch) begin
          sym_d     = cmd_i.sym;
          is_text_d = (cmd_i.op == OP_TEXT);
          eot_d     = cmd_i.eot;
          case (cmd_i.op)
            OP_CLEAR: begin
              plen_d = '0;
              pref_d = '0;
              mp_d   = '0;
              tp_d   = '0;
            end
            OP_APPEND: begin
              if (!plen_full) begin
                p_we = 1'b1;
                if (plen_zero) begin
                  // first byte has no proper prefix-suffix
                  f_we   = 1'b1;
                  pref_d = '0;
                  plen_d = LW'(1);
                end else begin
                  j_d     = LW'(pref_q);
                  p_raddr = pref_q;
                end
              end
            end
            OP_TEXT: begin
              if (plen_zero) begin
                tp_d = tp_q + POS_W'(1);
                if (cmd_i.eot) begin
                  tp_d = '0;
                  mp_d = '0;
                end
              end else begin
                j_d     = j_start;
                p_raddr = j_start[IW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        if (fin) begin
          if (!is_text_q) begin
            // close the append: store the new failure link
            f_we    = 1'b1;
            f_wdata = j_fin[IW-1:0];
            pref_d  = j_fin[IW-1:0];
            plen_d  = plen_q + LW'(1);
          end else begin
            if (j_fin == plen_q) begin
              // full match: report start and fall back to the longest border
              out_vld_d = 1'b1;
              out_d     = tp_q + POS_W'(1) - POS_W'(plen_q);
              mp_d      = LW'(pref_q);
            end else begin
              mp_d = j_fin;
            end
            tp_d = tp_q + POS_W'(1);
            if (eot_q) begin
              tp_d = '0;
              mp_d = '0;
            end
          end
        end
      end
      ST_FAIL: begin
        // follow the failure link and fetch the next byte to compare
        j_d     = j_fail;
        p_raddr = j_fail[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      j_q       <= '0;
      is_text_q <= 1'b0;
      eot_q     <= 1'b0;
      plen_q    <= '0;
      pref_q    <= '0;
      mp_q      <= '0;
      tp_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      j_q       <= j_d;
      is_text_q <= is_text_d;
      eot_q     <= eot_d;
      plen_q    <= plen_d;
      pref_q    <= pref_d;
      mp_q      <= mp_d;
      tp_q      <= tp_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

FILE: hdl/kmp_stream_matcher_top.sv
// Streaming Knuth-Morris-Pratt matcher.
// in_i carries requests: clear pattern, append a pattern byte, or a text
// byte with an end-of-text flag. out_o carries the 32-bit text position of
// the first byte of each completed match, overlapping matches included.
// Both channels move an item when valid and ready are high at a clock edge.
// A two-entry queue takes items while the back engine works; in_i.ready
// drops only when that queue is full. Undefined request codes drop at the input.
// In the engine a clear, an append to an empty or a full pattern, or a text
// byte with no pattern is handled in the idle state alone. Any other append
// or text byte goes through the compare state, and each failure-link step
// adds the fail state and the compare state again, as the pattern and
// failure memories are read through a register. Failure steps average at
// most one per text byte. The engine takes a new item only in its idle state.
// out_o.valid is registered: it rises at the edge that ends the engine's last
// compare state on the byte, after the queue and the idle-state dispatch.
// Reset empties the queue and sets pattern length, match progress and text
// position to zero; the memories are not cleared and need no pass.
// While out_o is stalled the engine holds the next text byte in the queue;
// clears and appends go on.
`default_nettype none

`include "kmp_stream_matcher_top_assert.svh"

module kmp_stream_matcher_top import kmp_pkg::*; #(
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kmp_in_if.sink    in_i,
  kmp_out_if.source out_o
);

  cmd_t cmd;
  logic cmd_vld;
  logic cmd_pop;

  // Accept and classify items
  kmp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cmd_o     (cmd),
    .cmd_vld_o (cmd_vld),
    .cmd_pop_i (cmd_pop)
  );

  // Run the matcher
  kmp_back #(.MAX_PATTERN(MAX_PATTERN)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cmd_vld_i (cmd_vld),
    .cmd_pop_o (cmd_pop),
    .out_o     (out_o)
  );

  // The engine never takes from an empty queue
  `KMP_ASSERT_NOW(a_pop_needs_item, cmd_pop, cmd_vld)
  // A full queue is never empty
  `KMP_ASSERT_NOW(a_stall_means_full, !in_i.ready, cmd_vld)
  // An accepted request with a defined code lands in the queue
  `KMP_ASSERT_NEXT(a_push_lands, in_i.valid && in_i.ready && (in_i.req_type <= REQ_TEXT), cmd_vld)

endmodule

`default_nettype wire
